/* hw/rtl/sortable_stack_with_search_defines.svh */
// assertion macros for the sortable stack with search
`ifndef SORTABLE_STACK_WITH_SEARCH_DEFINES_SVH
`define SORTABLE_STACK_WITH_SEARCH_DEFINES_SVH

`ifndef ASSERT_OFF
`define SSS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define SSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SSS_ASSERT(lbl, expr, msg)
`define SSS_ASSERT_IMPL(lbl, ante, cons, msg)
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/sss_pkg.sv */
// types and constants shared by the sortable stack with search
`timescale 1ns / 1ps

package sss_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;

  localparam logic [ReqW-1:0] REQ_PUSH   = 3'd0;
  localparam logic [ReqW-1:0] REQ_POP    = 3'd1;
  localparam logic [ReqW-1:0] REQ_PEEK   = 3'd2;
  localparam logic [ReqW-1:0] REQ_SEARCH = 3'd3;
  localparam logic [ReqW-1:0] REQ_SORT   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY     = 2'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEEK,
    S_SRCH,
    S_SORT_LD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_RESP
  } state_e;

endpackage

/* hw/rtl/sss_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module sss_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/sortable_stack_with_search.sv */
// push, pop, unknown codes and requests with too few entries go straight to the response state
// peek: one ram read of the top; search: reads from the bottom up, stopping at a match or the top
// sort: insertion sort over the one ram, shifting larger entries up
// one request in flight; a new request is taken once the result is queued
// reset (async, active low) empties the stack; entries stay unset until pushed
`timescale 1ns / 1ps
`include "sortable_stack_with_search_defines.svh"

module sortable_stack_with_search #(
  parameter int unsigned STACK_DEPTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sss_pkg::ReqW-1:0]     req_type_i,
  input  logic signed [sss_pkg::DataW-1:0] operand_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sss_pkg::StatusW-1:0]  status_o,
  output logic signed [sss_pkg::DataW-1:0] top_value_o,
  output logic [sss_pkg::CountW-1:0]   entry_count_out_o
);

  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  sss_pkg::state_e state_q, state_d;

  logic [CntW-1:0]                count_q, count_d;
  logic [IdxW-1:0]                i_q, i_d;
  logic [IdxW-1:0]                j_q, j_d;
  logic [sss_pkg::DataW-1:0]      opnd_q, opnd_d;
  logic [sss_pkg::StatusW-1:0]    res_status_q, res_status_d;
  logic [sss_pkg::DataW-1:0]      res_top_q, res_top_d;
  logic                           out_valid_q, out_valid_d;
  logic [sss_pkg::StatusW-1:0]    out_status_q, out_status_d;
  logic [sss_pkg::DataW-1:0]      out_top_q, out_top_d;
  logic [sss_pkg::CountW-1:0]     out_count_q, out_count_d;

  logic                      ram_we;
  logic [IdxW-1:0]           ram_waddr;
  logic [sss_pkg::DataW-1:0] ram_wdata;
  logic [IdxW-1:0]           ram_raddr;
  logic [sss_pkg::DataW-1:0] ram_rdata;

  logic            accept;
  logic            full;
  logic            empty;
  logic            multi;
  logic [CntW-1:0] cnt_m1;
  logic            last_i;
  logic            out_free;
  logic [sss_pkg::DataW:0] diff;
  logic            lt;
  logic            eq;
  logic [CntW+sss_pkg::CountW-1:0] cnt_ext;

  sss_ram #(
    .Width(sss_pkg::DataW),
    .Depth(STACK_DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  assign in_stall_o = (state_q != sss_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(STACK_DEPTH));
  assign empty      = (count_q == '0);
  assign multi      = (count_q > CntW'(1));
  assign cnt_m1     = count_q - CntW'(1);
  assign last_i     = ((CntW'(i_q) + CntW'(1)) == count_q);
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared signed comparator: held operand against ram read data
  assign diff = {opnd_q[sss_pkg::DataW-1], opnd_q} - {ram_rdata[sss_pkg::DataW-1], ram_rdata};
  assign lt   = diff[sss_pkg::DataW];
  assign eq   = (diff == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sss_pkg::S_IDLE: begin
        if (accept) begin
          state_d = sss_pkg::S_RESP;
          if (req_type_i == sss_pkg::REQ_PEEK && !empty) begin
            state_d = sss_pkg::S_PEEK;
          end else if (req_type_i == sss_pkg::REQ_SEARCH && !empty) begin
            state_d = sss_pkg::S_SRCH;
          end else if (req_type_i == sss_pkg::REQ_SORT && multi) begin
            state_d = sss_pkg::S_SORT_LD;
          end
        end
      end
      sss_pkg::S_PEEK: state_d = sss_pkg::S_RESP;
      sss_pkg::S_SRCH: begin
        if (eq || last_i) begin
          state_d = sss_pkg::S_RESP;
        end
      end
      sss_pkg::S_SORT_LD: state_d = sss_pkg::S_SORT_CMP;
      sss_pkg::S_SORT_CMP: begin
        if (lt) begin
          if (j_q == IdxW'(1)) begin
            state_d = sss_pkg::S_SORT_PUT;
          end
        end else begin
          state_d = last_i ? sss_pkg::S_RESP : sss_pkg::S_SORT_LD;
        end
      end
      sss_pkg::S_SORT_PUT: begin
        state_d = last_i ? sss_pkg::S_RESP : sss_pkg::S_SORT_LD;
      end
      sss_pkg::S_RESP: begin
        if (out_free) begin
          state_d = sss_pkg::S_IDLE;
        end
      end
      default: state_d = sss_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = opnd_q;
    ram_raddr    = '0;
    count_d      = count_q;
    i_d          = i_q;
    j_d          = j_q;
    opnd_d       = opnd_q;
    res_status_d = res_status_q;
    res_top_d    = res_top_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_top_d    = out_top_q;
    out_count_d  = out_count_q;

    unique case (state_q)
      sss_pkg::S_IDLE: begin
        if (accept) begin
          opnd_d       = operand_value_i;
          res_top_d    = '0;
          res_status_d = sss_pkg::ST_OK;
          unique case (req_type_i)
            sss_pkg::REQ_PUSH: begin
              if (full) begin
                res_status_d = sss_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IdxW-1:0];
                ram_wdata = operand_value_i;
                count_d   = count_q + CntW'(1);
              end
            end
            sss_pkg::REQ_POP: begin
              if (empty) begin
                res_status_d = sss_pkg::ST_EMPTY;
              end else begin
                count_d = cnt_m1;
              end
            end
            sss_pkg::REQ_PEEK: begin
              if (empty) begin
                res_status_d = sss_pkg::ST_EMPTY;
              end
              ram_raddr = cnt_m1[IdxW-1:0];
            end
            sss_pkg::REQ_SEARCH: begin
              res_status_d = sss_pkg::ST_NOT_FOUND;
              i_d          = '0;
            end
            sss_pkg::REQ_SORT: begin
              ram_raddr = IdxW'(1);
              i_d       = IdxW'(1);
            end
            default: ;
          endcase
        end
      end
      sss_pkg::S_PEEK: res_top_d = ram_rdata;
      sss_pkg::S_SRCH: begin
        if (eq) begin
          res_status_d = sss_pkg::ST_OK;
        end else if (!last_i) begin
          i_d       = i_q + IdxW'(1);
          ram_raddr = i_q + IdxW'(1);
        end
      end
      sss_pkg::S_SORT_LD: begin
        // pick up the entry to insert and start walking down from it
        opnd_d    = ram_rdata;
        j_d       = i_q;
        ram_raddr = i_q - IdxW'(1);
      end
      sss_pkg::S_SORT_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        if (lt) begin
          // shift the larger entry up one slot
          ram_wdata = ram_rdata;
          j_d       = j_q - IdxW'(1);
          ram_raddr = j_q - IdxW'(2);
        end else begin
          ram_wdata = opnd_q;
          if (!last_i) begin
            i_d       = i_q + IdxW'(1);
            ram_raddr = i_q + IdxW'(1);
          end
        end
      end
      sss_pkg::S_SORT_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = opnd_q;
        if (!last_i) begin
          i_d       = i_q + IdxW'(1);
          ram_raddr = i_q + IdxW'(1);
        end
      end
      sss_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_top_d    = res_top_q;
          out_count_d  = cnt_ext[sss_pkg::CountW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign cnt_ext = {{sss_pkg::CountW{1'b0}}, count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sss_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q          <= i_d;
    j_q          <= j_d;
    opnd_q       <= opnd_d;
    res_status_q <= res_status_d;
    res_top_q    <= res_top_d;
    out_status_q <= out_status_d;
    out_top_q    <= out_top_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign top_value_o       = out_top_q;
  assign entry_count_out_o = out_count_q;

  `SSS_ASSERT(a_count_range, count_q <= CntW'(STACK_DEPTH), "entry count above depth")
  `SSS_ASSERT_NEXT(a_push_count, accept && req_type_i == sss_pkg::REQ_PUSH && !full, count_q == $past(count_q) + CntW'(1), "push did not grow the stack")
  `SSS_ASSERT_NEXT(a_count_busy, state_q != sss_pkg::S_IDLE, $stable(count_q), "entry count moved while busy")
  `SSS_ASSERT_IMPL(a_sort_walk, state_q == sss_pkg::S_SORT_CMP, j_q != '0 && j_q <= i_q && CntW'(i_q) < count_q, "sort indices out of range")
  `SSS_ASSERT_NEXT(a_result_load, state_q == sss_pkg::S_RESP && out_free, out_valid_q && state_q == sss_pkg::S_IDLE, "result not queued")

endmodule
